FILE: hdl/dam_pkg.sv
// Shared types and constants of the decimal accumulator machine.
package dam_pkg;

   localparam int MEM_WORDS = 100;
   localparam int ADDR_BITS = 7;
   localparam int HALT_WORD = 4300;
   // Instruction words whose magnitude is at or above this cannot hold a valid opcode.
   localparam int INST_LIMIT = 4400;
   // Reciprocal of 100 scaled by 2^19; exact for magnitudes below the limit above.
   localparam int RECIP_100 = 5243;
   localparam int RECIP_SHIFT = 19;

   localparam logic [5:0] OPC_READ   = 6'd10;
   localparam logic [5:0] OPC_WRITE  = 6'd11;
   localparam logic [5:0] OPC_LOAD   = 6'd20;
   localparam logic [5:0] OPC_STORE  = 6'd21;
   localparam logic [5:0] OPC_ADD    = 6'd30;
   localparam logic [5:0] OPC_SUB    = 6'd31;
   localparam logic [5:0] OPC_DIV    = 6'd32;
   localparam logic [5:0] OPC_MUL    = 6'd33;
   localparam logic [5:0] OPC_BR     = 6'd40;
   localparam logic [5:0] OPC_BRNEG  = 6'd41;
   localparam logic [5:0] OPC_BRZERO = 6'd42;
   localparam logic [5:0] OPC_HALT   = 6'd43;

   localparam logic [2:0] ST_OK   = 3'd0;
   localparam logic [2:0] ST_HALT = 3'd1;
   localparam logic [2:0] ST_BAD  = 3'd2;
   localparam logic [2:0] ST_DIV0 = 3'd3;
   localparam logic [2:0] ST_PC   = 3'd4;

   typedef enum logic [3:0] {
      OP_READ, OP_WRITE, OP_LOAD, OP_STORE, OP_ADD, OP_SUB, OP_DIV, OP_MUL,
      OP_BR, OP_BRNEG, OP_BRZERO, OP_HALT, OP_BAD
   } op_type;

   typedef enum logic [2:0] {
      ACC_HOLD, ACC_LOAD, ACC_ADD, ACC_SUB, ACC_MUL, ACC_DIV
   } acc_op_type;

   typedef enum logic [1:0] {MW_NONE, MW_LOAD, MW_READ, MW_ACC} mem_wr_type;

   typedef enum logic [1:0] {PC_HOLD, PC_INC, PC_JUMP} pc_op_type;

   typedef struct packed {
      logic       capture;
      logic       fetch;
      logic       decode;
      logic       sel_opnd;
      acc_op_type acc_op;
      mem_wr_type mem_wr;
      logic       show_out;
      logic       take_read;
      pc_op_type  pc_op;
      logic       stop_wr;
      logic [2:0] stop_code;
      logic       mul_start;
      logic       div_start;
      logic       iter_step;
   } cmd_type;

   typedef struct packed {
      logic   kind;
      logic   stopped;
      logic   pc_oor;
      op_type op;
      logic   acc_neg;
      logic   acc_zero;
      logic   m_zero;
      logic   iter_done;
   } stat_type;

endpackage

FILE: hdl/decimal_accumulator_machine.sv
// Top level of the decimal accumulator machine: controller plus datapath.
// A load beat, a step on a stopped machine or a step with the program counter past the
// last memory word gives its result in the cycle after acceptance; other step beats run
// fetch, decode, operand read and execute, and multiply, or divide by a nonzero word,
// adds the one-bit-per-cycle iteration. One beat is in flight at a time, so the next
// beat is taken only after the result. Synchronous reset clears PC, accumulator and
// stop code and marks every memory word unwritten, so it reads as a halt instruction.
module decimal_accumulator_machine #(
   parameter int WORD_BITS = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_kind,
   input  logic [6:0]         req_load_address,
   input  logic signed [14:0] req_load_value,
   input  logic signed [14:0] req_read_value,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [2:0]         rsp_status,
   output logic [6:0]         rsp_program_counter,
   output logic signed [31:0] rsp_acc_value,
   output logic               rsp_out_valid,
   output logic signed [31:0] rsp_out_word,
   output logic               rsp_read_taken
);

   dam_pkg::cmd_type  cmd;
   dam_pkg::stat_type stat;

   dam_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   dam_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .req_kind            (req_kind),
      .req_load_address    (req_load_address),
      .req_load_value      (req_load_value),
      .req_read_value      (req_read_value),
      .rsp_status          (rsp_status),
      .rsp_program_counter (rsp_program_counter),
      .rsp_acc_value       (rsp_acc_value),
      .rsp_out_valid       (rsp_out_valid),
      .rsp_out_word        (rsp_out_word),
      .rsp_read_taken      (rsp_read_taken)
   );

endmodule

FILE: hdl/dam_ram.sv
// Generic single write port RAM with one registered read port.
module dam_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 100
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata <= mem_ff[raddr];
   end

endmodule

FILE: hdl/dam_datapath.sv
// Datapath: word memory, registers, decoder and the shared multiply/divide unit.
module dam_datapath #(
   parameter int WORD_BITS = 32
) (
   input  logic                 clock,
   input  logic                 reset,
   input  dam_pkg::cmd_type     cmd,
   output dam_pkg::stat_type    stat,
   input  logic                 req_kind,
   input  logic [6:0]           req_load_address,
   input  logic signed [14:0]   req_load_value,
   input  logic signed [14:0]   req_read_value,
   output logic [2:0]           rsp_status,
   output logic [6:0]           rsp_program_counter,
   output logic signed [31:0]   rsp_acc_value,
   output logic                 rsp_out_valid,
   output logic signed [31:0]   rsp_out_word,
   output logic                 rsp_read_taken
);

   localparam int W = WORD_BITS;
   localparam int CNT_BITS = $clog2(WORD_BITS + 1);
   localparam int AB = dam_pkg::ADDR_BITS;

   function automatic logic [W-1:0] magnitude(input logic [W-1:0] w);
      return w[W-1] ? (~w + W'(1)) : w;
   endfunction

   logic [AB-1:0]        pc_ff, pc_in;
   logic [W-1:0]         acc_ff, acc_in;
   logic [2:0]           stop_ff, stop_in;
   logic [W-1:0]         inst_ff, inst_in;
   dam_pkg::op_type      op_ff, op_in;
   logic [AB-1:0]        opnd_ff, opnd_in;
   logic [W-1:0]         rdv_ff, rdv_in;
   logic                 outv_ff, outv_in;
   logic [W-1:0]         outw_ff, outw_in;
   logic                 taken_ff, taken_in;
   logic [W-1:0]         a_ff, a_in, b_ff, b_in, p_ff, p_in;
   logic [CNT_BITS-1:0]  cnt_ff, cnt_in;
   logic                 div_mode_ff, div_mode_in;
   logic                 neg_ff, neg_in;
   logic [dam_pkg::MEM_WORDS-1:0] vld_ff, vld_in;
   logic                 vld_rd_ff;

   logic                 we;
   logic [AB-1:0]        waddr, raddr;
   logic [W-1:0]         wdata, rdata, mword;
   logic [12:0]          dec_x;
   logic [25:0]          dec_prod;
   logic [5:0]           dec_q;
   logic [12:0]          dec_rem;
   logic [W-1:0]         div_rs;
   logic [63:0]          acc_wide, outw_wide;

   assign raddr = cmd.sel_opnd ? opnd_ff : pc_ff;
   // A word never written since reset reads as a halt instruction.
   assign mword = vld_rd_ff ? rdata : W'(dam_pkg::HALT_WORD);

   always_comb begin
      we = 1'b0;
      waddr = opnd_ff;
      wdata = acc_ff;
      unique case (cmd.mem_wr)
         dam_pkg::MW_LOAD: begin
            we = req_load_address < AB'(dam_pkg::MEM_WORDS);
            waddr = req_load_address;
            wdata = W'(req_load_value);
         end
         dam_pkg::MW_READ: begin
            we = 1'b1;
            wdata = rdv_ff;
         end
         dam_pkg::MW_ACC: begin
            we = 1'b1;
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   dam_ram #(.WIDTH(W), .DEPTH(dam_pkg::MEM_WORDS)) u_ram (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (raddr),
      .rdata (rdata)
   );

   // Opcode is value / 100 by reciprocal multiplication, operand the remainder.
   assign dec_x = inst_ff[12:0];
   assign dec_prod = 26'(dec_x) * 26'(dam_pkg::RECIP_100);
   assign dec_q = dec_prod[dam_pkg::RECIP_SHIFT +: 6];
   assign dec_rem = dec_x - 13'(dec_q) * 13'd100;
   assign div_rs = {p_ff[W-2:0], a_ff[W-1]};

   always_comb begin
      pc_in = pc_ff;
      acc_in = acc_ff;
      stop_in = stop_ff;
      inst_in = inst_ff;
      op_in = op_ff;
      opnd_in = opnd_ff;
      rdv_in = rdv_ff;
      outv_in = outv_ff;
      outw_in = outw_ff;
      taken_in = taken_ff;
      a_in = a_ff;
      b_in = b_ff;
      p_in = p_ff;
      cnt_in = cnt_ff;
      div_mode_in = div_mode_ff;
      neg_in = neg_ff;
      vld_in = vld_ff;

      if (we) begin
         vld_in[waddr] = 1'b1;
      end
      if (cmd.capture) begin
         rdv_in = W'(req_read_value);
         outv_in = 1'b0;
         outw_in = '0;
         taken_in = 1'b0;
      end
      if (cmd.fetch) begin
         inst_in = magnitude(mword);
      end
      if (cmd.decode) begin
         opnd_in = dec_rem[AB-1:0];
         if (inst_ff >= W'(dam_pkg::INST_LIMIT)) begin
            op_in = dam_pkg::OP_BAD;
         end else begin
            case (dec_q)
               dam_pkg::OPC_READ:   op_in = dam_pkg::OP_READ;
               dam_pkg::OPC_WRITE:  op_in = dam_pkg::OP_WRITE;
               dam_pkg::OPC_LOAD:   op_in = dam_pkg::OP_LOAD;
               dam_pkg::OPC_STORE:  op_in = dam_pkg::OP_STORE;
               dam_pkg::OPC_ADD:    op_in = dam_pkg::OP_ADD;
               dam_pkg::OPC_SUB:    op_in = dam_pkg::OP_SUB;
               dam_pkg::OPC_DIV:    op_in = dam_pkg::OP_DIV;
               dam_pkg::OPC_MUL:    op_in = dam_pkg::OP_MUL;
               dam_pkg::OPC_BR:     op_in = dam_pkg::OP_BR;
               dam_pkg::OPC_BRNEG:  op_in = dam_pkg::OP_BRNEG;
               dam_pkg::OPC_BRZERO: op_in = dam_pkg::OP_BRZERO;
               dam_pkg::OPC_HALT:   op_in = dam_pkg::OP_HALT;
               default:             op_in = dam_pkg::OP_BAD;
            endcase
         end
      end
      if (cmd.show_out) begin
         outv_in = 1'b1;
         outw_in = mword;
      end
      if (cmd.take_read) begin
         taken_in = 1'b1;
      end
      if (cmd.mul_start) begin
         a_in = acc_ff;
         b_in = mword;
         p_in = '0;
         cnt_in = CNT_BITS'(W);
         div_mode_in = 1'b0;
      end
      if (cmd.div_start) begin
         a_in = magnitude(acc_ff);
         b_in = magnitude(mword);
         p_in = '0;
         cnt_in = CNT_BITS'(W);
         div_mode_in = 1'b1;
         neg_in = acc_ff[W-1] ^ mword[W-1];
      end
      if (cmd.iter_step && cnt_ff != '0) begin
         cnt_in = cnt_ff - CNT_BITS'(1);
         if (div_mode_ff) begin
            // Restoring division: one quotient bit per beat of the counter.
            if (div_rs >= b_ff) begin
               p_in = div_rs - b_ff;
               a_in = {a_ff[W-2:0], 1'b1};
            end else begin
               p_in = div_rs;
               a_in = {a_ff[W-2:0], 1'b0};
            end
         end else begin
            if (b_ff[0]) begin
               p_in = p_ff + a_ff;
            end
            a_in = {a_ff[W-2:0], 1'b0};
            b_in = {1'b0, b_ff[W-1:1]};
         end
      end
      unique case (cmd.acc_op)
         dam_pkg::ACC_LOAD: acc_in = mword;
         dam_pkg::ACC_ADD:  acc_in = acc_ff + mword;
         dam_pkg::ACC_SUB:  acc_in = acc_ff - mword;
         dam_pkg::ACC_MUL:  acc_in = p_ff;
         dam_pkg::ACC_DIV:  acc_in = neg_ff ? (~a_ff + W'(1)) : a_ff;
         default:           acc_in = acc_ff;
      endcase
      unique case (cmd.pc_op)
         dam_pkg::PC_INC:  pc_in = pc_ff + AB'(1);
         dam_pkg::PC_JUMP: pc_in = opnd_ff;
         default:          pc_in = pc_ff;
      endcase
      if (cmd.stop_wr) begin
         stop_in = cmd.stop_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= '0;
         acc_ff <= '0;
         stop_ff <= dam_pkg::ST_OK;
         vld_ff <= '0;
         cnt_ff <= '0;
         outv_ff <= 1'b0;
         taken_ff <= 1'b0;
      end else begin
         pc_ff <= pc_in;
         acc_ff <= acc_in;
         stop_ff <= stop_in;
         vld_ff <= vld_in;
         cnt_ff <= cnt_in;
         outv_ff <= outv_in;
         taken_ff <= taken_in;
      end
      vld_rd_ff <= vld_ff[raddr];
      inst_ff <= inst_in;
      op_ff <= op_in;
      opnd_ff <= opnd_in;
      rdv_ff <= rdv_in;
      outw_ff <= outw_in;
      a_ff <= a_in;
      b_ff <= b_in;
      p_ff <= p_in;
      div_mode_ff <= div_mode_in;
      neg_ff <= neg_in;
   end

   always_comb begin
      stat.kind = req_kind;
      stat.stopped = stop_ff != dam_pkg::ST_OK;
      stat.pc_oor = pc_ff >= AB'(dam_pkg::MEM_WORDS);
      stat.op = op_ff;
      stat.acc_neg = acc_ff[W-1];
      stat.acc_zero = acc_ff == '0;
      stat.m_zero = mword == '0;
      stat.iter_done = cnt_ff == '0;
   end

   assign acc_wide = 64'(acc_ff);
   assign outw_wide = 64'(outw_ff);
   assign rsp_status = stop_ff;
   assign rsp_program_counter = pc_ff;
   assign rsp_acc_value = signed'(acc_wide[31:0]);
   assign rsp_out_valid = outv_ff;
   assign rsp_out_word = signed'(outw_wide[31:0]);
   assign rsp_read_taken = taken_ff;

   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      stop_ff != dam_pkg::ST_OK |=> $stable(stop_ff))
      else $error("stop code changed after the machine stopped");
   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= AB'(dam_pkg::MEM_WORDS))
      else $error("program counter beyond memory end plus one");
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_BITS'(W))
      else $error("iteration counter out of range");
   a_out_excl: assert property (@(posedge clock) disable iff (reset)
      !(outv_ff && taken_ff))
      else $error("write and read reported for the same step");

endmodule

FILE: hdl/dam_control.sv
// Controller state machine sequencing load and instruction beats.
module dam_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  dam_pkg::stat_type stat,
   output dam_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE, S_FETCH, S_DECODE, S_OPREAD, S_EXEC, S_MUL, S_DIV, S_RESP
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = state_ff == S_IDLE;
   assign rsp_valid = state_ff == S_RESP;

   always_comb begin
      cmd = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in = S_RESP;
               if (!stat.kind) begin
                  cmd.mem_wr = dam_pkg::MW_LOAD;
               end else if (stat.stopped) begin
                  state_in = S_RESP;
               end else if (stat.pc_oor) begin
                  cmd.stop_wr = 1'b1;
                  cmd.stop_code = dam_pkg::ST_PC;
               end else begin
                  state_in = S_FETCH;
               end
            end
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in = S_DECODE;
         end
         S_DECODE: begin
            cmd.decode = 1'b1;
            state_in = S_OPREAD;
         end
         S_OPREAD: begin
            cmd.sel_opnd = 1'b1;
            state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_RESP;
            cmd.pc_op = dam_pkg::PC_INC;
            unique case (stat.op)
               dam_pkg::OP_READ: begin
                  cmd.mem_wr = dam_pkg::MW_READ;
                  cmd.take_read = 1'b1;
               end
               dam_pkg::OP_WRITE:  cmd.show_out = 1'b1;
               dam_pkg::OP_LOAD:   cmd.acc_op = dam_pkg::ACC_LOAD;
               dam_pkg::OP_STORE:  cmd.mem_wr = dam_pkg::MW_ACC;
               dam_pkg::OP_ADD:    cmd.acc_op = dam_pkg::ACC_ADD;
               dam_pkg::OP_SUB:    cmd.acc_op = dam_pkg::ACC_SUB;
               dam_pkg::OP_DIV: begin
                  cmd.pc_op = dam_pkg::PC_HOLD;
                  if (stat.m_zero) begin
                     cmd.stop_wr = 1'b1;
                     cmd.stop_code = dam_pkg::ST_DIV0;
                  end else begin
                     cmd.div_start = 1'b1;
                     state_in = S_DIV;
                  end
               end
               dam_pkg::OP_MUL: begin
                  cmd.pc_op = dam_pkg::PC_HOLD;
                  cmd.mul_start = 1'b1;
                  state_in = S_MUL;
               end
               dam_pkg::OP_BR:     cmd.pc_op = dam_pkg::PC_JUMP;
               dam_pkg::OP_BRNEG: begin
                  if (stat.acc_neg) begin
                     cmd.pc_op = dam_pkg::PC_JUMP;
                  end
               end
               dam_pkg::OP_BRZERO: begin
                  if (stat.acc_zero) begin
                     cmd.pc_op = dam_pkg::PC_JUMP;
                  end
               end
               dam_pkg::OP_HALT: begin
                  cmd.pc_op = dam_pkg::PC_HOLD;
                  cmd.stop_wr = 1'b1;
                  cmd.stop_code = dam_pkg::ST_HALT;
               end
               default: begin
                  cmd.pc_op = dam_pkg::PC_HOLD;
                  cmd.stop_wr = 1'b1;
                  cmd.stop_code = dam_pkg::ST_BAD;
               end
            endcase
         end
         S_MUL, S_DIV: begin
            if (stat.iter_done) begin
               cmd.acc_op = (state_ff == S_MUL) ? dam_pkg::ACC_MUL : dam_pkg::ACC_DIV;
               cmd.pc_op = dam_pkg::PC_INC;
               state_in = S_RESP;
            end else begin
               cmd.iter_step = 1'b1;
            end
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_one_start: assert property (@(posedge clock) disable iff (reset)
      !(cmd.mul_start && cmd.div_start))
      else $error("multiply and divide started together");
   a_resp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat withdrawn before it was taken");
   a_no_write_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.mem_wr == dam_pkg::MW_LOAD |-> state_ff == S_IDLE)
      else $error("load write outside the idle state");

endmodule

FILE: tb/sv/tb_decimal_accumulator_machine.sv
// Self-checking testbench for the decimal accumulator machine.
`timescale 1ns / 1ps

module tb_decimal_accumulator_machine;

   localparam int CYCLE_LIMIT = 600000;
   localparam int HOLD_CYCLES = 500;

   typedef struct {
      logic [2:0]  status;
      logic [6:0]  pc;
      logic [31:0] acc;
      logic        out_valid;
      logic [31:0] out_word;
      logic        read_taken;
   } outcome_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic               req_kind = 1'b0;
   logic [6:0]         req_load_address = '0;
   logic signed [14:0] req_load_value = '0;
   logic signed [14:0] req_read_value = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [2:0]         rsp_status;
   logic [6:0]         rsp_program_counter;
   logic signed [31:0] rsp_acc_value;
   logic               rsp_out_valid;
   logic signed [31:0] rsp_out_word;
   logic               rsp_read_taken;

   // Predicted machine state.
   logic [31:0] word_mem [dam_pkg::MEM_WORDS];
   logic [6:0]  pc_now;
   logic [31:0] acc_now;
   logic [2:0]  stop_now;

   outcome_type pending_outcomes[$];
   int       mismatches = 0;
   int       cycles = 0;
   int       idle_pct = 0;
   int       stall_pct = 0;
   int       hold_asked = 0;
   int       hold_served = 0;
   int       hold_left = 0;

   logic [5:0] run_ops [11] = '{
      dam_pkg::OPC_READ, dam_pkg::OPC_WRITE, dam_pkg::OPC_LOAD, dam_pkg::OPC_STORE,
      dam_pkg::OPC_ADD, dam_pkg::OPC_SUB, dam_pkg::OPC_DIV, dam_pkg::OPC_MUL,
      dam_pkg::OPC_BR, dam_pkg::OPC_BRNEG, dam_pkg::OPC_BRZERO};

   decimal_accumulator_machine dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("decimal_accumulator_machine regression: fail");
         $finish;
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever one is asked for.
   always @(negedge clock) begin
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   function automatic logic [31:0] abs_word(logic [31:0] w);
      return w[31] ? -w : w;
   endfunction

   function automatic outcome_type advance_machine(logic kind, logic [6:0] addr,
                                                   logic [14:0] lval, logic [14:0] rval);
      outcome_type o;
      logic [31:0] mag, opc, opnd, m, q;
      logic [6:0]  nxt;
      o.out_valid = 1'b0;
      o.out_word = '0;
      o.read_taken = 1'b0;
      if (!kind) begin
         if (addr < dam_pkg::MEM_WORDS) word_mem[addr] = {{17{lval[14]}}, lval};
      end else if (stop_now == dam_pkg::ST_OK) begin
         if (pc_now >= dam_pkg::MEM_WORDS) begin
            stop_now = dam_pkg::ST_PC;
         end else begin
            mag = abs_word(word_mem[pc_now]);
            opc = mag / 100;
            opnd = mag % 100;
            nxt = pc_now + 7'd1;
            m = word_mem[opnd];
            case (opc)
               dam_pkg::OPC_READ: begin
                  word_mem[opnd] = {{17{rval[14]}}, rval};
                  o.read_taken = 1'b1;
               end
               dam_pkg::OPC_WRITE: begin
                  o.out_valid = 1'b1;
                  o.out_word = m;
               end
               dam_pkg::OPC_LOAD:  acc_now = m;
               dam_pkg::OPC_STORE: word_mem[opnd] = acc_now;
               dam_pkg::OPC_ADD:   acc_now = acc_now + m;
               dam_pkg::OPC_SUB:   acc_now = acc_now - m;
               dam_pkg::OPC_DIV: begin
                  if (m == 0) begin
                     stop_now = dam_pkg::ST_DIV0;
                     nxt = pc_now;
                  end else begin
                     q = abs_word(acc_now) / abs_word(m);
                     acc_now = (acc_now[31] != m[31]) ? -q : q;
                  end
               end
               dam_pkg::OPC_MUL:    acc_now = acc_now * m;
               dam_pkg::OPC_BR:     nxt = opnd[6:0];
               dam_pkg::OPC_BRNEG:  if (acc_now[31]) nxt = opnd[6:0];
               dam_pkg::OPC_BRZERO: if (acc_now == 0) nxt = opnd[6:0];
               dam_pkg::OPC_HALT: begin
                  stop_now = dam_pkg::ST_HALT;
                  nxt = pc_now;
               end
               default: begin
                  stop_now = dam_pkg::ST_BAD;
                  nxt = pc_now;
               end
            endcase
            pc_now = nxt;
         end
      end
      o.status = stop_now;
      o.pc = pc_now;
      o.acc = acc_now;
      return o;
   endfunction

   task automatic report_field(string name, logic [31:0] exp, logic [31:0] act);
      if (exp !== act) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp, act);
      end
   endtask

   always @(posedge clock) begin
      outcome_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outcomes.size() == 0) begin
            mismatches++;
            $display("%0t: result beat with none expected", $time);
         end else begin
            e = pending_outcomes.pop_front();
            report_field("status", e.status, rsp_status);
            report_field("program_counter", e.pc, rsp_program_counter);
            report_field("acc_value", e.acc, rsp_acc_value);
            report_field("out_valid", e.out_valid, rsp_out_valid);
            report_field("out_word", e.out_word, rsp_out_word);
            report_field("read_taken", e.read_taken, rsp_read_taken);
         end
      end
   end

   // Offers one beat; valid stays high afterwards unless the next call idles.
   task automatic offer_beat(logic kind, logic [6:0] addr, logic [14:0] lval,
                             logic [14:0] rval);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_kind <= kind;
      req_load_address <= addr;
      req_load_value <= lval;
      req_read_value <= rval;
      pending_outcomes.insert(pending_outcomes.size(), advance_machine(kind, addr, lval, rval));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic load_word(logic [6:0] addr, logic signed [14:0] val);
      offer_beat(1'b0, addr, val, 15'($urandom));
   endtask

   task automatic step_once(logic signed [14:0] rval);
      offer_beat(1'b1, 7'($urandom), 15'($urandom), rval);
   endtask

   function automatic logic signed [14:0] encode(logic [5:0] opc, int opnd);
      logic signed [14:0] w;
      w = 15'(opc * 100 + opnd);
      return $urandom_range(1) ? -w : w;
   endfunction

   // Places one instruction at the current program counter and executes it.
   task automatic run_instruction(logic [5:0] opc, int opnd, logic signed [14:0] rval);
      load_word(pc_now, encode(opc, opnd));
      step_once(rval);
   endtask

   task automatic test_load_extremes();
      load_word(7'd0, -15'sd16384);
      load_word(7'd99, 15'sd16383);
      load_word(7'd100, 15'sd1234);
      load_word(7'd127, -15'sd1);
      load_word(7'd50, -15'sd9999);
      load_word(7'd51, 15'sd9999);
   endtask

   task automatic test_every_opcode();
      run_instruction(dam_pkg::OPC_READ, 52, -15'sd16384);
      run_instruction(dam_pkg::OPC_WRITE, 52, 15'sd0);
      run_instruction(dam_pkg::OPC_LOAD, 51, 15'sd0);
      run_instruction(dam_pkg::OPC_ADD, 50, 15'sd0);
      run_instruction(dam_pkg::OPC_BRZERO, 12, 15'sd0);
      run_instruction(dam_pkg::OPC_SUB, 50, 15'sd0);
      run_instruction(dam_pkg::OPC_BRNEG, 3, 15'sd0);
      run_instruction(dam_pkg::OPC_MUL, 51, 15'sd0);
      run_instruction(dam_pkg::OPC_DIV, 50, 15'sd0);
      run_instruction(dam_pkg::OPC_STORE, 53, 15'sd0);
      run_instruction(dam_pkg::OPC_SUB, 51, 15'sd0);
      run_instruction(dam_pkg::OPC_SUB, 51, 15'sd0);
      run_instruction(dam_pkg::OPC_BRNEG, 20, 15'sd0);
      run_instruction(dam_pkg::OPC_BR, 5, 15'sd0);
   endtask

   task automatic test_divide_overflow();
      // -16384 * 131072 gives exactly the most negative word, then it is divided by -1.
      load_word(7'd60, -15'sd16384);
      load_word(7'd61, 15'sd16384 - 15'sd1);
      load_word(7'd63, -15'sd1);
      load_word(7'd66, 15'sd8);
      load_word(7'd67, 15'sd16);
      run_instruction(dam_pkg::OPC_LOAD, 60, 15'sd0);
      run_instruction(dam_pkg::OPC_MUL, 66, 15'sd0);
      run_instruction(dam_pkg::OPC_MUL, 67, 15'sd0);
      run_instruction(dam_pkg::OPC_MUL, 66, 15'sd0);
      run_instruction(dam_pkg::OPC_MUL, 67, 15'sd0);
      run_instruction(dam_pkg::OPC_MUL, 66, 15'sd0);
      run_instruction(dam_pkg::OPC_STORE, 64, 15'sd0);
      run_instruction(dam_pkg::OPC_DIV, 63, 15'sd0);
   endtask

   function automatic bit runs_clean(logic [31:0] w);
      logic [31:0] mag, opc;
      mag = abs_word(w);
      opc = mag / 100;
      if (pc_now == 7'd99) return opc == dam_pkg::OPC_BR;
      if (opc == dam_pkg::OPC_DIV) return word_mem[mag % 100] != 0;
      return opc inside {dam_pkg::OPC_READ, dam_pkg::OPC_WRITE, dam_pkg::OPC_LOAD,
                         dam_pkg::OPC_STORE, dam_pkg::OPC_ADD, dam_pkg::OPC_SUB,
                         dam_pkg::OPC_MUL, dam_pkg::OPC_BR, dam_pkg::OPC_BRNEG,
                         dam_pkg::OPC_BRZERO};
   endfunction

   task automatic test_random_program(int count, int idle, int stall, bit hold);
      logic [5:0]         opc;
      int                 opnd;
      logic signed [14:0] w;
      idle_pct = idle;
      stall_pct = stall;
      if (hold) hold_asked++;
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) == 0) begin
            load_word($urandom_range(7) == 0 ? 7'($urandom) : 7'($urandom_range(99)),
                      15'($urandom));
         end else begin
            if (!runs_clean(word_mem[pc_now]) || $urandom_range(2) == 0) begin
               do begin
                  opc = (pc_now == 7'd99) ? dam_pkg::OPC_BR : run_ops[$urandom_range(10)];
                  opnd = $urandom_range(99);
                  w = encode(opc, opnd);
               end while (!runs_clean({{17{w[14]}}, w}));
               load_word(pc_now, w);
            end
            step_once(15'($urandom));
         end
      end
   endtask

   task automatic test_stop_and_after();
      idle_pct = 10;
      stall_pct = 10;
      case ($urandom_range(3))
         0: run_instruction(dam_pkg::OPC_HALT, 0, 15'sd0);
         1: begin
            load_word(7'd70, 15'sd0);
            run_instruction(dam_pkg::OPC_DIV, 70, 15'sd0);
         end
         2: begin
            run_instruction(dam_pkg::OPC_BR, 99, 15'sd0);
            run_instruction(dam_pkg::OPC_LOAD, 0, 15'sd0);
            step_once(15'sd0);
         end
         default: begin
            if ($urandom_range(1)) begin
               load_word(pc_now, 15'sd9999);
               step_once(15'sd0);
            end else begin
               // The most negative word decodes to an invalid opcode.
               test_divide_overflow();
               run_instruction(dam_pkg::OPC_BR, 64, 15'sd0);
               step_once(15'sd0);
            end
         end
      endcase
      for (int i = 0; i < 6; i++) begin
         step_once(15'($urandom));
         load_word(7'($urandom_range(99)), 15'($urandom));
      end
   endtask

   initial begin
      foreach (word_mem[i]) word_mem[i] = dam_pkg::HALT_WORD;
      pc_now = '0;
      acc_now = '0;
      stop_now = dam_pkg::ST_OK;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_load_extremes();
      test_every_opcode();
      test_divide_overflow();
      test_random_program(140, 0, 0, 1'b0);
      test_random_program(140, 88, 0, 1'b0);
      test_random_program(140, 0, 88, 1'b0);
      test_random_program(140, 32, 32, 1'b0);
      test_random_program(20, 0, 0, 1'b1);
      test_stop_and_after();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_outcomes.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0)
         $display("decimal_accumulator_machine regression: pass");
      else
         $display("decimal_accumulator_machine regression: fail");
      $finish;
   end

endmodule
